// ===== hdl/triangle_xz_containment_search_top_macros.svh =====
// assertion macros for the triangle xz containment search checker
`ifndef TRIANGLE_XZ_CONTAINMENT_SEARCH_TOP_MACROS_SVH
`define TRIANGLE_XZ_CONTAINMENT_SEARCH_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define TXZ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%s failed", "label");

// implication whose consequent is checked in the cycle after the antecedent
`define TXZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%s failed", "label");

`endif

// ===== hdl/txz_pkg.sv =====
// shared constants for the triangle xz containment search
package txz_pkg;
   localparam int MODE_BITS = 2;
   localparam int IDX_BITS = 12;
   localparam int TERR_BITS = 8;
   localparam int MARGIN_BITS = 8;

   localparam logic [MODE_BITS-1:0] MODE_WR_VERTEX = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_WR_TRI = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd2;

   localparam logic [1:0] PART_NORMAL = 2'd3;

   localparam logic [0:0] CSR_EDGE_MARGIN = 1'd0;
   localparam logic [0:0] CSR_TERRAIN_EN = 1'd1;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 8;
endpackage

// ===== hdl/txz_stream_if.sv =====
// valid/ready channel carrying a payload struct or vector
interface txz_stream_if #(parameter int WIDTH = 8);
   logic valid;
   logic ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/txz_ram.sv =====
// generic single write port ram with registered read
module txz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/txz_front.sv =====
// front end: accepts transactions, drops the unused mode, queues work
module txz_front #(
   parameter int QW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [QW-1:0] in_data,
   output logic          q_valid,
   input  logic          q_pop,
   output logic [QW-1:0] q_data
);
   import txz_pkg::*;
   // two-entry queue
   logic [QW-1:0] slot_ff [2];
   logic [1:0]    cnt_ff, cnt_in;
   logic          rp_ff, rp_in, wp_ff, wp_in;
   logic          push;
   logic [MODE_BITS-1:0] mode;

   assign mode = in_data[MODE_BITS-1:0];
   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready &&
                 (mode == MODE_WR_VERTEX || mode == MODE_WR_TRI || mode == MODE_QUERY);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ q_pop;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_data;
      if (reset) begin
         cnt_ff <= '0; rp_ff <= 1'b0; wp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; rp_ff <= rp_in; wp_ff <= wp_in;
      end
   end
endmodule

// ===== hdl/txz_back.sv =====
// back end: mesh stores, triangle scan and result sequencing
module txz_back #(
   parameter int VERTEX_SLOTS = 4096,
   parameter int TRIANGLE_SLOTS = 4096,
   parameter int COORD_BITS = 24,
   parameter int QW = 8,
   parameter int OW = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   output logic                             q_pop,
   input  logic [QW-1:0]                    q_data,
   input  logic [txz_pkg::MARGIN_BITS-1:0]  margin,
   input  logic                             terr_en,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [OW-1:0]                    out_data
);
   import txz_pkg::*;
   localparam int VA = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
   localparam int TA = (TRIANGLE_SLOTS > 1) ? $clog2(TRIANGLE_SLOTS) : 1;
   localparam int C = COORD_BITS;
   localparam int CW = 3 * IDX_BITS;
   localparam int CE = C + 1;

   // unpack queued transaction (layout set by top)
   logic [MODE_BITS-1:0] f_mode;
   logic [IDX_BITS-1:0]  f_idx, f_ca, f_cb, f_cc, f_start;
   logic signed [C-1:0]  f_x, f_y, f_z;
   logic [TERR_BITS-1:0] f_terr;
   assign {f_start, f_terr, f_cc, f_cb, f_ca, f_z, f_y, f_x, f_idx, f_mode} = q_data;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_TRI = 7'b0000010, S_VA = 7'b0000100,
      S_VB = 7'b0001000, S_VC = 7'b0010000, S_TEST = 7'b0100000,
      S_EMIT = 7'b1000000
   } state_type;
   state_type st_ff, st_in;

   logic [TA-1:0]  tri_ff, tri_in;
   logic [1:0]     part_ff, part_in;
   logic           hit_ff, hit_in;
   logic signed [CE-1:0] hx_ff, lx_ff, hz_ff, lz_ff;
   logic [2:0][IDX_BITS-1:0] crn_ff;
   logic [2:0][3*C-1:0]      vtx_ff;
   logic [2:0]               voob_ff;
   logic [3*C-1:0]           nrm_ff;
   logic [TERR_BITS-1:0]     ter_ff;
   logic                     ovld_ff;
   logic [OW-1:0]            odat_ff;

   // stores
   logic          vw, tw;
   logic [VA-1:0] v_ra;
   logic [3*C-1:0] v_rd, n_rd;
   logic [CW-1:0] c_rd;
   logic [TERR_BITS-1:0] t_rd;
   logic [IDX_BITS-1:0] rd_corner;

   assign vw = (st_ff == S_IDLE) && q_valid && f_mode == MODE_WR_VERTEX &&
               {20'd0, f_idx} < 32'(VERTEX_SLOTS);
   assign tw = (st_ff == S_IDLE) && q_valid && f_mode == MODE_WR_TRI &&
               {20'd0, f_idx} < 32'(TRIANGLE_SLOTS);

   always_comb begin
      case (st_ff)
         S_VA: rd_corner = c_rd[IDX_BITS-1:0];
         S_VB: rd_corner = crn_ff[1];
         default: rd_corner = crn_ff[2];
      endcase
   end
   assign v_ra = VA'(rd_corner);

   txz_ram #(.WIDTH(3*C), .DEPTH(VERTEX_SLOTS)) u_vtx (
      .clock, .wr_en(vw), .wr_addr(VA'(f_idx)), .wr_data({f_z, f_y, f_x}),
      .rd_addr(v_ra), .rd_data(v_rd));
   txz_ram #(.WIDTH(CW), .DEPTH(TRIANGLE_SLOTS)) u_crn (
      .clock, .wr_en(tw), .wr_addr(TA'(f_idx)), .wr_data({f_cc, f_cb, f_ca}),
      .rd_addr(tri_ff), .rd_data(c_rd));
   txz_ram #(.WIDTH(3*C), .DEPTH(TRIANGLE_SLOTS)) u_nrm (
      .clock, .wr_en(tw), .wr_addr(TA'(f_idx)), .wr_data({f_z, f_y, f_x}),
      .rd_addr(tri_ff), .rd_data(n_rd));
   txz_ram #(.WIDTH(TERR_BITS), .DEPTH(TRIANGLE_SLOTS)) u_ter (
      .clock, .wr_en(tw), .wr_addr(TA'(f_idx)), .wr_data(f_terr),
      .rd_addr(tri_ff), .rd_data(t_rd));

   function automatic logic oob(input logic [IDX_BITS-1:0] i);
      return {20'd0, i} >= 32'(VERTEX_SLOTS);
   endfunction

   // corner test against the margin window
   logic [2:0] xl, xg, zl, zg;
   logic       inside_w;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [CE-1:0] vx, vz;
         logic [3*C-1:0] vsrc;
         // third corner is still on the vertex read port during the test
         vsrc = (k == 2) ? v_rd : vtx_ff[k];
         vx = voob_ff[k] ? '0 : CE'(signed'(vsrc[C-1:0]));
         vz = voob_ff[k] ? '0 : CE'(signed'(vsrc[3*C-1:2*C]));
         xl[k] = vx <= hx_ff; xg[k] = vx >= lx_ff;
         zl[k] = vz <= hz_ff; zg[k] = vz >= lz_ff;
      end
      inside_w = (|xl) && (|xg) && (|zl) && (|zg);
   end

   logic out_free;
   assign out_free = !ovld_ff || out_ready;
   assign out_valid = ovld_ff;
   assign out_data = odat_ff;

   logic [TA-1:0] start_sat;
   assign start_sat = ({20'd0, f_start} > 32'(TRIANGLE_SLOTS - 1)) ?
                      TA'(TRIANGLE_SLOTS - 1) : TA'(f_start);

   logic [3*C-1:0] sel_v;
   always_comb begin
      sel_v = voob_ff[part_ff] ? '0 : vtx_ff[part_ff];
      if (part_ff == PART_NORMAL) sel_v = nrm_ff;
   end

   always_comb begin
      st_in = st_ff; tri_in = tri_ff; part_in = part_ff; hit_in = hit_ff;
      q_pop = 1'b0;
      case (st_ff)
         S_IDLE: if (q_valid) begin
            if (f_mode == MODE_QUERY) begin
               tri_in = start_sat; st_in = S_TRI;
            end else q_pop = 1'b1;
         end
         S_TRI: st_in = S_VA;
         S_VA: st_in = S_VB;
         S_VB: st_in = S_VC;
         S_VC: st_in = S_TEST;
         S_TEST: begin
            part_in = '0;
            if (inside_w) begin hit_in = 1'b1; st_in = S_EMIT; end
            else if (tri_ff == '0) begin hit_in = 1'b0; st_in = S_EMIT; end
            else begin tri_in = tri_ff - 1'b1; st_in = S_TRI; end
         end
         S_EMIT: if (out_free) begin
            part_in = part_ff + 1'b1;
            if (!hit_ff || part_ff == PART_NORMAL) begin
               st_in = S_IDLE; q_pop = 1'b1;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && q_valid) begin
         hx_ff <= CE'(signed'(f_x)) + CE'(margin);
         lx_ff <= CE'(signed'(f_x)) - CE'(margin);
         hz_ff <= CE'(signed'(f_z)) + CE'(margin);
         lz_ff <= CE'(signed'(f_z)) - CE'(margin);
      end
      // read pipeline: corner row, then three vertex reads
      if (st_ff == S_VA) begin
         crn_ff <= c_rd; nrm_ff <= n_rd; ter_ff <= t_rd;
         voob_ff[0] <= oob(c_rd[IDX_BITS-1:0]);
         voob_ff[1] <= oob(c_rd[2*IDX_BITS-1:IDX_BITS]);
         voob_ff[2] <= oob(c_rd[3*IDX_BITS-1:2*IDX_BITS]);
      end
      if (st_ff == S_VB) vtx_ff[0] <= v_rd;
      if (st_ff == S_VC) vtx_ff[1] <= v_rd;
      if (st_ff == S_TEST) vtx_ff[2] <= v_rd;
      if (st_ff == S_EMIT && out_free) begin
         if (hit_ff)
            odat_ff <= {part_ff == PART_NORMAL, sel_v, part_ff,
                        terr_en ? ter_ff : TERR_BITS'(0), IDX_BITS'(tri_ff), 1'b1};
         else
            odat_ff <= {1'b1, (OW-1)'(0)};
      end
      if (reset) begin
         st_ff <= S_IDLE; ovld_ff <= 1'b0; tri_ff <= '0; part_ff <= '0; hit_ff <= 1'b0;
      end else begin
         st_ff <= st_in; tri_ff <= tri_in; part_ff <= part_in; hit_ff <= hit_in;
         if (st_ff == S_EMIT && out_free) ovld_ff <= 1'b1;
         else if (out_ready) ovld_ff <= 1'b0;
      end
   end
   // third vertex arrives in test: compared from the read port, kept for the results
endmodule

// ===== hdl/triangle_xz_containment_search_top.sv =====
// top level of the triangle xz containment search
// a write reaches its store when the back end, idle, takes it from the queue; a query
// steps S_TRI, S_VA, S_VB, S_VC, S_TEST per triangle tested (corner row, then three
// vertex reads), then S_EMIT, one result per cycle while rsp_ready holds; one item in
// the back end at a time behind a two-entry queue that accepts while not full; sync
// reset clears control, sets edge_margin 3 and terrain off, and keeps the mesh stores
module triangle_xz_containment_search_top #(
   parameter int VERTEX_SLOTS = 4096,
   parameter int TRIANGLE_SLOTS = 4096,
   parameter int COORD_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [txz_pkg::MODE_BITS-1:0] req_mode,
   input  logic [txz_pkg::IDX_BITS-1:0]  req_entry_index,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   input  logic signed [COORD_BITS-1:0]  req_coord_z,
   input  logic [txz_pkg::IDX_BITS-1:0]  req_corner_a,
   input  logic [txz_pkg::IDX_BITS-1:0]  req_corner_b,
   input  logic [txz_pkg::IDX_BITS-1:0]  req_corner_c,
   input  logic [txz_pkg::TERR_BITS-1:0] req_terrain_code,
   input  logic [txz_pkg::IDX_BITS-1:0]  req_start_triangle,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_found,
   output logic [txz_pkg::IDX_BITS-1:0]  rsp_triangle_number,
   output logic [txz_pkg::TERR_BITS-1:0] rsp_terrain_type,
   output logic [1:0]                    rsp_part,
   output logic signed [COORD_BITS-1:0]  rsp_out_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_y,
   output logic signed [COORD_BITS-1:0]  rsp_out_z,
   output logic rsp_last,
   input  logic csr_we,
   input  logic [txz_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [txz_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import txz_pkg::*;
   localparam int QW = MODE_BITS + 5*IDX_BITS + 3*COORD_BITS + TERR_BITS;
   localparam int OW = 1 + IDX_BITS + TERR_BITS + 2 + 3*COORD_BITS + 1;

   logic [MARGIN_BITS-1:0] margin_ff;
   logic                   terr_en_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_BITS'(3); terr_en_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == CSR_EDGE_MARGIN) margin_ff <= csr_wdata;
         if (csr_index == CSR_TERRAIN_EN) terr_en_ff <= csr_wdata[0];
      end
   end

   txz_stream_if #(.WIDTH(QW)) req_if ();
   txz_stream_if #(.WIDTH(QW)) q_if ();
   txz_stream_if #(.WIDTH(OW)) rsp_if ();

   assign req_if.valid = req_valid;
   assign req_ready = req_if.ready;
   assign req_if.data = {req_start_triangle, req_terrain_code, req_corner_c, req_corner_b,
                         req_corner_a, req_coord_z, req_coord_y, req_coord_x,
                         req_entry_index, req_mode};

   txz_front #(.QW(QW)) u_front (
      .clock, .reset, .in_valid(req_if.valid), .in_ready(req_if.ready),
      .in_data(req_if.data), .q_valid(q_if.valid), .q_pop(q_if.ready),
      .q_data(q_if.data));

   txz_back #(.VERTEX_SLOTS(VERTEX_SLOTS), .TRIANGLE_SLOTS(TRIANGLE_SLOTS),
              .COORD_BITS(COORD_BITS), .QW(QW), .OW(OW)) u_back (
      .clock, .reset, .q_valid(q_if.valid), .q_pop(q_if.ready), .q_data(q_if.data),
      .margin(margin_ff), .terr_en(terr_en_ff), .out_valid(rsp_if.valid),
      .out_ready(rsp_if.ready), .out_data(rsp_if.data));

   assign rsp_valid = rsp_if.valid;
   assign rsp_if.ready = rsp_ready;
   assign {rsp_last, rsp_out_z, rsp_out_y, rsp_out_x, rsp_part, rsp_terrain_type,
           rsp_triangle_number, rsp_found} = rsp_if.data;
endmodule

// ===== hdl/txz_checker.sv =====
// port-level checker for the triangle xz containment search, bound to the top
`include "triangle_xz_containment_search_top_macros.svh"
module txz_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic rsp_last,
   input logic [1:0] rsp_part,
   input logic [11:0] rsp_triangle_number
);
   `TXZ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TXZ_ASSERT_IMP(a_miss_single, clock, reset, rsp_valid && !rsp_found,
      rsp_last && rsp_part == 2'd0 && rsp_triangle_number == 12'd0)
   `TXZ_ASSERT_IMP(a_last_normal, clock, reset, rsp_valid && rsp_found,
      rsp_last == (rsp_part == 2'd3))
   `TXZ_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_found) && $stable(rsp_last) && $stable(rsp_part) && $stable(rsp_triangle_number))
endmodule

bind triangle_xz_containment_search_top txz_checker u_txz_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_found, .rsp_last, .rsp_part,
   .rsp_triangle_number);
